### hw/rtl/erm_pkg.sv
// erm_pkg: shared constants and codes of the event rate and staleness monitor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package erm_pkg;

  // ring geometry default
  localparam int RING_DEPTH_DEF = 64;

  // rate arithmetic
  localparam int unsigned MHZ_SCALE    = 1000000;
  localparam int unsigned RATE_MAX_MHZ = 1000000000;

  // command codes
  localparam logic [1:0] CMD_FULL  = 2'd0;
  localparam logic [1:0] CMD_PART  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // level codes
  localparam logic [1:0] LVL_OK    = 2'd0;
  localparam logic [1:0] LVL_WARN  = 2'd1;
  localparam logic [1:0] LVL_ERROR = 2'd2;
  localparam logic [1:0] LVL_STALE = 2'd3;

  // reason codes
  localparam logic [2:0] RSN_OK       = 3'd0;
  localparam logic [2:0] RSN_NEVER    = 3'd1;
  localparam logic [2:0] RSN_TIMEOUT  = 3'd2;
  localparam logic [2:0] RSN_RATE_LOW = 3'd3;
  localparam logic [2:0] RSN_RATE_CRIT = 3'd4;

  // source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_FULL = 2'd1;
  localparam logic [1:0] SRC_PART = 2'd2;

  // register indexes
  localparam logic [2:0] REG_EXPECTED   = 3'd0;
  localparam logic [2:0] REG_WARN_RATIO = 3'd1;
  localparam logic [2:0] REG_ERR_RATIO  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_WINDOW     = 3'd4;
  localparam logic [2:0] REG_STALE_ERR  = 3'd5;
  localparam logic [2:0] REG_RATE_ERR   = 3'd6;

  // register reset values
  localparam logic [19:0] EXPECTED_RST   = 20'd1000;
  localparam logic [8:0]  WARN_RATIO_RST = 9'd179;
  localparam logic [8:0]  ERR_RATIO_RST  = 9'd102;
  localparam logic [31:0] TIMEOUT_RST    = 32'd5000;
  localparam logic [31:0] WINDOW_RST     = 32'd6000;

endpackage

`default_nettype wire

### hw/rtl/erm_ring_mem.sv
// erm_ring_mem: arrival time ring storage, one write and one registered read port
// depends on erm_pkg for the default depth
`timescale 1ns / 1ps
`default_nettype none

module erm_ring_mem
  import erm_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF,
  parameter int AW    = $clog2(RING_DEPTH_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/erm_divider.sv
// erm_divider: restoring divider, one quotient bit per cycle
// depends on erm_pkg; divisor is 32 bits and never zero when started
`timescale 1ns / 1ps
`default_nettype none

module erm_divider
  import erm_pkg::*;
#(
  parameter int NUM_W = 27
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [31:0]      denom,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [31:0]      den;
  logic [32:0]      trial;
  logic             fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= denom;
        quot <= numer;
      end else if (busy) begin
        rem  <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
        quot <= {quot[NUM_W-2:0], fits};
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/event_rate_staleness_monitor_unit.sv
// event_rate_staleness_monitor_unit: top level of the stream rate and staleness monitor
// depends on erm_pkg, erm_ring_mem and erm_divider
//
//   channel  | handshake                  | moves
//   ---------+----------------------------+------------------------------------------
//   item     | item_valid / item_ready    | command, time_ms, map_width, map_height,
//            |                            | resolution_um
//   result   | result_valid / result_ready| level, reason, actual_rate_mhz, elapsed_ms,
//            |                            | source_out, width_out, height_out, resolution_out
//   config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// an arrival then reads and checks the oldest ring entry, dropping it and reading again
// while it lies outside the window (the newest entry always stays), paced by the single
// read port of the ring memory
// a never-seen or timed-out query goes straight to the decision; one with under two
// stored times first forms the threshold products; one with equal newest and oldest times
// also reads the newest entry; a full rate query waits on the one-bit-per-cycle divider
// reset is synchronous; the ring itself is not cleared, only head and count
// a finished result waits in the output register while the next transaction is taken;
// a query that finds it still full stalls with item_ready low until it drains
`timescale 1ns / 1ps
`default_nettype none

module event_rate_staleness_monitor_unit
  import erm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] time_ms,
  input  wire logic [15:0] map_width,
  input  wire logic [15:0] map_height,
  input  wire logic [15:0] resolution_um,
  // result channel
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic      [1:0]  level,
  output logic      [2:0]  reason,
  output logic      [29:0] actual_rate_mhz,
  output logic      [31:0] elapsed_ms,
  output logic      [1:0]  source_out,
  output logic      [15:0] width_out,
  output logic      [15:0] height_out,
  output logic      [15:0] resolution_out,
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW    = $clog2(RING_DEPTH + 1);
  // (count-1) * 1e6 always fits in CW+20 bits
  localparam int NUM_W = CW + 20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PR_RD,
    ST_PR_CHK,
    ST_Q_EVAL,
    ST_Q_NEW,
    ST_Q_SPAN,
    ST_Q_DIV,
    ST_MUL,
    ST_DECIDE
  } state_t;

  state_t state;

  // configuration registers
  logic [19:0] expected_rate;
  logic [8:0]  warn_ratio;
  logic [8:0]  err_ratio;
  logic [31:0] timeout_lim;
  logic [31:0] window;
  logic        stale_err_en;
  logic        rate_err_en;

  // stream state
  logic [AW-1:0] head;
  logic [CW-1:0] ring_count;
  logic [31:0]   last_arrival;
  logic          seen_any;
  logic [1:0]    source_kept;
  logic [15:0]   width_kept;
  logic [15:0]   height_kept;
  logic [15:0]   resolution_kept;

  // per-transaction working registers
  logic [31:0] now;
  logic [31:0] elapsed;
  logic [31:0] oldest;
  logic [29:0] rate;
  logic        q_never;
  logic        q_timeout;
  logic [28:0] err_prod;
  logic [28:0] warn_prod;

  // ring access
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rdata;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] newest_idx;
  logic [CW:0]   tail_sum;
  logic [CW:0]   newest_sum;
  logic          ring_full;
  logic          accept;
  logic          is_arrival;

  // rate path
  logic [31:0]      span;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_numer;
  logic [NUM_W-1:0] div_quot;
  logic [37:0]      scaled;
  logic             below_err;
  logic             below_warn;
  logic             res_load;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign is_arrival = (command == CMD_FULL) || (command == CMD_PART);
  assign ring_full  = (ring_count == CW'(RING_DEPTH));

  // modular ring indexes, operands always below twice the depth
  assign head_inc = (head == AW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;

  always_comb begin
    tail_sum = (CW+1)'(head) + (CW+1)'(ring_count);
    if (tail_sum >= (CW+1)'(RING_DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(RING_DEPTH);
    end
    tail_idx = tail_sum[AW-1:0];
    newest_sum = (CW+1)'(head) + (CW+1)'(ring_count) - 1'b1;
    if (newest_sum >= (CW+1)'(RING_DEPTH)) begin
      newest_sum = newest_sum - (CW+1)'(RING_DEPTH);
    end
    newest_idx = newest_sum[AW-1:0];
  end

  // the new time goes in at the accept edge; every read is issued later
  assign mem_we  = accept && is_arrival;
  assign wr_addr = ring_full ? head : tail_idx;
  assign rd_addr = (state == ST_Q_NEW) ? newest_idx : head;

  erm_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (time_ms),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign span      = rdata - oldest;
  assign div_start = (state == ST_Q_SPAN) && (span != '0);
  assign div_numer = NUM_W'(ring_count - 1'b1) * NUM_W'(MHZ_SCALE);

  erm_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign scaled     = {rate, 8'b0};
  assign below_err  = (scaled < 38'(err_prod));
  assign below_warn = (scaled < 38'(warn_prod));

  // the result register takes a new status once it is free or being emptied
  assign res_load = (state == ST_DECIDE) && (!result_valid || result_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate <= EXPECTED_RST;
      warn_ratio    <= WARN_RATIO_RST;
      err_ratio     <= ERR_RATIO_RST;
      timeout_lim   <= TIMEOUT_RST;
      window        <= WINDOW_RST;
      stale_err_en  <= 1'b1;
      rate_err_en   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED:   expected_rate <= cfg_data[19:0];
        REG_WARN_RATIO: warn_ratio    <= cfg_data[8:0];
        REG_ERR_RATIO:  err_ratio     <= cfg_data[8:0];
        REG_TIMEOUT:    timeout_lim   <= cfg_data;
        REG_WINDOW:     window        <= cfg_data;
        REG_STALE_ERR:  stale_err_en  <= cfg_data[0];
        REG_RATE_ERR:   rate_err_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer: state, stream state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      head            <= '0;
      ring_count      <= '0;
      last_arrival    <= '0;
      seen_any        <= 1'b0;
      source_kept     <= SRC_NONE;
      width_kept      <= '0;
      height_kept     <= '0;
      resolution_kept <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            now <= time_ms;
            if (is_arrival) begin
              width_kept   <= map_width;
              height_kept  <= map_height;
              last_arrival <= time_ms;
              seen_any     <= 1'b1;
              if (command == CMD_FULL) begin
                resolution_kept <= resolution_um;
                source_kept     <= SRC_FULL;
              end else begin
                source_kept <= SRC_PART;
              end
              // a full ring drops its oldest entry
              if (ring_full) begin
                head <= head_inc;
              end else begin
                ring_count <= ring_count + 1'b1;
              end
              state <= ST_PR_RD;
            end else if (command == CMD_QUERY) begin
              state <= ST_Q_EVAL;
            end
          end
        end
        ST_PR_RD: begin
          // oldest entry is being read at head
          state <= (ring_count != '0) ? ST_PR_CHK : ST_IDLE;
        end
        ST_PR_CHK: begin
          if ((now - rdata) > window) begin
            head       <= head_inc;
            ring_count <= ring_count - 1'b1;
            state      <= ST_PR_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_Q_EVAL: begin
          // oldest entry read is in flight at head
          q_never   <= !seen_any;
          q_timeout <= seen_any && ((now - last_arrival) > timeout_lim);
          elapsed   <= seen_any ? (now - last_arrival) : '0;
          rate      <= '0;
          if (!seen_any || ((now - last_arrival) > timeout_lim)) begin
            state <= ST_DECIDE;
          end else if (ring_count < CW'(2)) begin
            state <= ST_MUL;
          end else begin
            state <= ST_Q_NEW;
          end
        end
        ST_Q_NEW: begin
          oldest <= rdata;
          state  <= ST_Q_SPAN;
        end
        ST_Q_SPAN: begin
          state <= (span != '0) ? ST_Q_DIV : ST_MUL;
        end
        ST_Q_DIV: begin
          if (div_done) begin
            rate  <= (32'(div_quot) > RATE_MAX_MHZ) ? 30'(RATE_MAX_MHZ) : 30'(div_quot);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          err_prod  <= 29'(err_ratio) * 29'(expected_rate);
          warn_prod <= 29'(warn_ratio) * 29'(expected_rate);
          state     <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // wait for the result register to be free
          if (res_load) begin
            elapsed_ms      <= elapsed;
            source_out      <= source_kept;
            width_out       <= width_kept;
            height_out      <= height_kept;
            resolution_out  <= resolution_kept;
            actual_rate_mhz <= (q_never || q_timeout) ? '0 : rate;
            if (q_never) begin
              level  <= stale_err_en ? LVL_STALE : LVL_WARN;
              reason <= RSN_NEVER;
            end else if (q_timeout) begin
              level  <= stale_err_en ? LVL_ERROR : LVL_WARN;
              reason <= RSN_TIMEOUT;
            end else if ((expected_rate != '0) && below_err) begin
              level  <= rate_err_en ? LVL_ERROR : LVL_WARN;
              reason <= rate_err_en ? RSN_RATE_CRIT : RSN_RATE_LOW;
            end else if ((expected_rate != '0) && below_warn) begin
              level  <= LVL_WARN;
              reason <= RSN_RATE_LOW;
            end else begin
              level  <= LVL_OK;
              reason <= RSN_OK;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(RING_DEPTH))
    else $error("ring count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(RING_DEPTH - 1))
    else $error("ring head beyond depth");

  a_arrival_kept: assert property (@(posedge clk) disable iff (rst)
    accept && is_arrival |=> ring_count != '0)
    else $error("arrival left the ring empty");

  a_never_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (reason == RSN_NEVER) |-> elapsed_ms == '0 && actual_rate_mhz == '0)
    else $error("never-seen result carries rate or elapsed time");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_Q_DIV)
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

### dv/event_rate_staleness_monitor_unit_tb.sv
// self-checking testbench for event_rate_staleness_monitor_unit: directed and random traffic
// against a cycle-free model of the arrival ring, staleness and rate checks
// depends on erm_pkg and the event_rate_staleness_monitor_unit rtl only
`timescale 1ns / 1ps

module event_rate_staleness_monitor_unit_tb;
  import erm_pkg::*;

  localparam int RING_SLOTS = RING_DEPTH_DEF;
  // an arrival may still be pruning when the last result lands: room for every entry plus slack
  localparam int SETTLE_CYCLES = 2 * RING_SLOTS + 18;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int IDLE_PCT      = 11;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [63:0] Q8_ONE      = 64'd256;

  typedef logic [$clog2(RING_SLOTS)-1:0] ring_idx_t;

  typedef struct {
    logic [1:0]  level;
    logic [2:0]  reason;
    logic [29:0] rate_mhz;
    logic [31:0] elapsed;
    logic [1:0]  source;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] resolution;
  } stream_status_t;

  // dut ports
  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  command;
  logic [31:0] time_ms;
  logic [15:0] map_width;
  logic [15:0] map_height;
  logic [15:0] resolution_um;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  level;
  logic [2:0]  reason;
  logic [29:0] actual_rate_mhz;
  logic [31:0] elapsed_ms;
  logic [1:0]  source_out;
  logic [15:0] width_out;
  logic [15:0] height_out;
  logic [15:0] resolution_out;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // model copy of the block state
  logic [31:0] arr_times [RING_SLOTS];
  ring_idx_t   arr_head     = '0;
  int          arr_count    = 0;
  logic [31:0] last_seen_ms = '0;
  logic        seen_flag    = 1'b0;
  logic [1:0]  src_kept     = SRC_NONE;
  logic [15:0] w_kept       = '0;
  logic [15:0] h_kept       = '0;
  logic [15:0] res_kept     = '0;

  // model copy of the registers, at their reset values
  logic [19:0] cfg_expected  = EXPECTED_RST;
  logic [8:0]  cfg_warn      = WARN_RATIO_RST;
  logic [8:0]  cfg_error     = ERR_RATIO_RST;
  logic [31:0] cfg_timeout   = TIMEOUT_RST;
  logic [31:0] cfg_window    = WINDOW_RST;
  logic        cfg_stale_err = 1'b1;
  logic        cfg_rate_err  = 1'b1;

  stream_status_t status_expected [$];

  bit          idling_enabled   = 1'b1;
  int          mismatch_count   = 0;
  int          items_sent       = 0;
  int          results_checked  = 0;
  int          settings_applied = 0;
  logic [31:0] stream_ms        = '0;

  event_rate_staleness_monitor_unit uut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .command         (command),
    .time_ms         (time_ms),
    .map_width       (map_width),
    .map_height      (map_height),
    .resolution_um   (resolution_um),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .level           (level),
    .reason          (reason),
    .actual_rate_mhz (actual_rate_mhz),
    .elapsed_ms      (elapsed_ms),
    .source_out      (source_out),
    .width_out       (width_out),
    .height_out      (height_out),
    .resolution_out  (resolution_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("event_rate_staleness_monitor_unit regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // messages per second times 1000 over the stored window, zero below two distinct times
  function automatic logic [29:0] window_rate_mhz();
    logic [31:0] span;
    logic [63:0] r;
    if (arr_count < 2) return '0;
    span = arr_times[ring_idx_t'(arr_head + arr_count - 1)] - arr_times[arr_head];
    if (span == 0) return '0;
    r = 64'(arr_count - 1) * 64'(MHZ_SCALE) / 64'(span);
    if (r > 64'(RATE_MAX_MHZ)) r = 64'(RATE_MAX_MHZ);
    return r[29:0];
  endfunction

  // advance the model by one accepted transaction; queries queue their status
  function automatic void update_stream_model(input logic [1:0] cmd, input logic [31:0] stamp,
                                              input logic [15:0] w, h, r);
    stream_status_t s;
    logic [63:0]    scaled;
    if (cmd == CMD_FULL || cmd == CMD_PART) begin
      w_kept = w;
      h_kept = h;
      if (cmd == CMD_FULL) res_kept = r;
      last_seen_ms = stamp;
      seen_flag    = 1'b1;
      src_kept     = (cmd == CMD_FULL) ? SRC_FULL : SRC_PART;
      // a full ring loses its oldest time to the new one
      if (arr_count >= RING_SLOTS) begin
        arr_times[arr_head] = stamp;
        arr_head = arr_head + 1'b1;
      end else begin
        arr_times[ring_idx_t'(arr_head + arr_count)] = stamp;
        arr_count++;
      end
      // drop times older than the window, oldest first
      while (arr_count > 0 && (stamp - arr_times[arr_head]) > cfg_window) begin
        arr_head = arr_head + 1'b1;
        arr_count--;
      end
    end else if (cmd == CMD_QUERY) begin
      s.level      = LVL_OK;
      s.reason     = RSN_OK;
      s.rate_mhz   = '0;
      s.elapsed    = '0;
      s.source     = src_kept;
      s.width      = w_kept;
      s.height     = h_kept;
      s.resolution = res_kept;
      if (!seen_flag) begin
        s.level  = cfg_stale_err ? LVL_STALE : LVL_WARN;
        s.reason = RSN_NEVER;
      end else begin
        s.elapsed = stamp - last_seen_ms;
        if (s.elapsed > cfg_timeout) begin
          s.level  = cfg_stale_err ? LVL_ERROR : LVL_WARN;
          s.reason = RSN_TIMEOUT;
        end else begin
          s.rate_mhz = window_rate_mhz();
          if (cfg_expected != 0) begin
            scaled = 64'(s.rate_mhz) * Q8_ONE;
            if (scaled < 64'(cfg_error) * 64'(cfg_expected)) begin
              s.level  = cfg_rate_err ? LVL_ERROR : LVL_WARN;
              s.reason = cfg_rate_err ? RSN_RATE_CRIT : RSN_RATE_LOW;
            end else if (scaled < 64'(cfg_warn) * 64'(cfg_expected)) begin
              s.level  = LVL_WARN;
              s.reason = RSN_RATE_LOW;
            end
          end
        end
      end
      status_expected.insert(status_expected.size(), s);
    end
  endfunction

  // one item transaction; valid stays high afterwards so the next item can follow at once
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] stamp,
                           input logic [15:0] w, h, r);
    while (idling_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    command       <= cmd;
    time_ms       <= stamp;
    map_width     <= w;
    map_height    <= h;
    resolution_um <= r;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    update_stream_model(cmd, stamp, w, h, r);
    items_sent++;
  endtask

  // hold off the sender until every status is back and any pruning has finished
  task automatic quiesce_stream();
    item_valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers the write enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_EXPECTED:   cfg_expected  = data[19:0];
      REG_WARN_RATIO: cfg_warn      = data[8:0];
      REG_ERR_RATIO:  cfg_error     = data[8:0];
      REG_TIMEOUT:    cfg_timeout   = data;
      REG_WINDOW:     cfg_window    = data;
      REG_STALE_ERR:  cfg_stale_err = data[0];
      REG_RATE_ERR:   cfg_rate_err  = data[0];
      default: ;
    endcase
  endtask

  // rewrite the whole register set; flag registers get junk in the unused upper bits
  task automatic program_settings(input logic [31:0] exp_mhz, warn_q8, err_q8, tmo, win,
                                  input bit stale_err, rate_err);
    quiesce_stream();
    write_reg(REG_EXPECTED,   exp_mhz);
    write_reg(REG_WARN_RATIO, warn_q8);
    write_reg(REG_ERR_RATIO,  err_q8);
    write_reg(REG_TIMEOUT,    tmo);
    write_reg(REG_WINDOW,     win);
    write_reg(REG_STALE_ERR,  {31'($urandom), stale_err});
    write_reg(REG_RATE_ERR,   {31'($urandom), rate_err});
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // settings scaled to the mean arrival gap so that every level turns up
  task automatic pick_random_settings(input int unsigned gap_max);
    logic [31:0] exp_mhz, warn_q8, err_q8, tmo, win;
    int unsigned nominal;
    nominal = 2000000 / (gap_max + 1);
    case ($urandom_range(0, 6))
      0:       exp_mhz = '0;
      1:       exp_mhz = 32'd1;
      2:       exp_mhz = 32'hFFFF_FFFF;
      3:       exp_mhz = 32'd1000000;
      default: exp_mhz = nominal * $urandom_range(1, 8) / 4;
    endcase
    case ($urandom_range(0, 4))
      0:       warn_q8 = '0;
      1:       warn_q8 = 32'd256;
      2:       warn_q8 = $urandom;
      default: warn_q8 = $urandom_range(128, 256);
    endcase
    case ($urandom_range(0, 4))
      0:       err_q8 = '0;
      1:       err_q8 = 32'd256;
      2:       err_q8 = $urandom;
      default: err_q8 = $urandom_range(0, 179);
    endcase
    case ($urandom_range(0, 4))
      0:       tmo = '0;
      1:       tmo = 32'hFFFF_FFFF;
      default: tmo = gap_max * $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 4))
      0:       win = '0;
      1:       win = 32'hFFFF_FFFF;
      default: win = gap_max * $urandom_range(1, 80);
    endcase
    program_settings(exp_mhz, warn_q8, err_q8, tmo, win, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
  endtask

  // random stream: mostly steady arrivals with queries between, rare clock jumps
  // and unknown commands; ignored items do not count towards n
  task automatic run_stream(input int n, input int unsigned gap_max, input int arrival_pct);
    int         done;
    int         kind;
    logic [1:0] cmd;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 2) stream_ms = $urandom;
      else stream_ms = stream_ms + $urandom_range(0, gap_max);
      kind = $urandom_range(0, 99);
      if (kind < 4) cmd = CMD_UNKNOWN;
      else if (kind < arrival_pct) cmd = $urandom_range(0, 1) ? CMD_PART : CMD_FULL;
      else cmd = CMD_QUERY;
      send_item(cmd, stream_ms, 16'($urandom), 16'($urandom), 16'($urandom));
      if (cmd != CMD_UNKNOWN) done++;
    end
  endtask

  // queries before any arrival, both flavours of the never-seen report
  task automatic test_unseen_stream();
    send_item(CMD_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_QUERY, 32'd0, 16'h0000, 16'h0000, 16'h0000);
    program_settings(32'(EXPECTED_RST), 32'(WARN_RATIO_RST), 32'(ERR_RATIO_RST), TIMEOUT_RST,
                     WINDOW_RST, 1'b0, 1'b1);
    send_item(CMD_QUERY, 32'd123, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    program_settings(32'(EXPECTED_RST), 32'(WARN_RATIO_RST), 32'(ERR_RATIO_RST), TIMEOUT_RST,
                     WINDOW_RST, 1'b1, 1'b1);
  endtask

  // hand-picked arrivals and queries: timeout boundary, clock wrap, every level path,
  // partial update keeping the resolution, zero span and extreme register values
  task automatic test_directed_levels();
    send_item(CMD_FULL,  32'd1000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_item(CMD_QUERY, 32'd1000, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_PART,  32'd2000, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(CMD_QUERY, 32'd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // elapsed equal to the timeout is still fresh, one more is not
    send_item(CMD_QUERY, 32'd7000, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_QUERY, 32'd7001, 16'h0000, 16'h0000, 16'h0000);
    // time wraps through zero between these two arrivals
    send_item(CMD_FULL,  32'hFFFF_FF00, 16'h1234, 16'h5678, 16'h9ABC);
    send_item(CMD_PART,  32'h0000_0100, 16'hAAAA, 16'h5555, 16'h0000);
    send_item(CMD_QUERY, 32'h0000_0200, 16'h0000, 16'h0000, 16'h0000);
    // rate error demoted to warn
    program_settings(32'd1000000, 32'd256, 32'd256, TIMEOUT_RST, WINDOW_RST, 1'b1, 1'b0);
    send_item(CMD_QUERY, 32'h0000_0200, 16'h0000, 16'h0000, 16'h0000);
    // warn path only
    program_settings(32'd1000000, 32'd256, 32'd0, TIMEOUT_RST, WINDOW_RST, 1'b1, 1'b1);
    send_item(CMD_QUERY, 32'h0000_0200, 16'h0000, 16'h0000, 16'h0000);
    // rate check switched off
    program_settings(32'd0, 32'd256, 32'd256, TIMEOUT_RST, WINDOW_RST, 1'b1, 1'b1);
    send_item(CMD_QUERY, 32'h0000_0200, 16'h0000, 16'h0000, 16'h0000);
    // zero timeout and zero window, staleness as warn
    program_settings(32'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    send_item(CMD_QUERY, 32'h0000_0100, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_QUERY, 32'h0000_0101, 16'h0000, 16'h0000, 16'h0000);
    // same timestamp twice: newest equals oldest
    send_item(CMD_PART,  32'h0000_0100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_QUERY, 32'h0000_0100, 16'h0000, 16'h0000, 16'h0000);
    // widest timeout and window
    program_settings(32'd1000, 32'd179, 32'd102, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(CMD_QUERY, 32'h8000_0100, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_UNKNOWN, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
    stream_ms = 32'h0000_0100;
  endtask

  // random phases, each under fresh settings
  task automatic test_random_traffic();
    int unsigned gap_max;
    for (int phase = 0; phase < 12; phase++) begin
      gap_max = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(50, 3000);
      pick_random_settings(gap_max);
      run_stream(110, gap_max, 60);
    end
  endtask

  // dense arrivals under an endless window so the ring fills and wraps
  task automatic test_ring_overflow();
    program_settings($urandom_range(0, 1000000), $urandom_range(0, 256),
                     $urandom_range(0, 256), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_stream(220, 30, 85);
  endtask

  // no idling on either side, with one pause until every status has come back
  task automatic test_back_to_back();
    idling_enabled = 1'b0;
    pick_random_settings(400);
    run_stream(80, 400, 60);
    quiesce_stream();
    run_stream(80, 400, 60);
    idling_enabled = 1'b1;
  endtask

  // result side: random back-pressure and the in-order status check
  always @(posedge clk) begin : status_check
    stream_status_t want;
    result_ready <= !(idling_enabled && $urandom_range(0, 99) < IDLE_PCT);
    if (!rst && result_valid && result_ready) begin
      if (status_expected.size() == 0) begin
        report_mismatch("status transaction with no query pending");
      end else begin
        want = status_expected[0];
        status_expected.delete(0);
        if (level !== want.level)
          report_mismatch($sformatf("level %0d, want %0d", level, want.level));
        if (reason !== want.reason)
          report_mismatch($sformatf("reason %0d, want %0d", reason, want.reason));
        if (actual_rate_mhz !== want.rate_mhz)
          report_mismatch($sformatf("rate %0d, want %0d", actual_rate_mhz, want.rate_mhz));
        if (elapsed_ms !== want.elapsed)
          report_mismatch($sformatf("elapsed %0d, want %0d", elapsed_ms, want.elapsed));
        if (source_out !== want.source)
          report_mismatch($sformatf("source %0d, want %0d", source_out, want.source));
        if (width_out !== want.width)
          report_mismatch($sformatf("width %0h, want %0h", width_out, want.width));
        if (height_out !== want.height)
          report_mismatch($sformatf("height %0h, want %0h", height_out, want.height));
        if (resolution_out !== want.resolution)
          report_mismatch($sformatf("resolution %0h, want %0h", resolution_out,
                                    want.resolution));
        results_checked++;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    command       <= CMD_FULL;
    time_ms       <= '0;
    map_width     <= '0;
    map_height    <= '0;
    resolution_um <= '0;
    result_ready  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_EXPECTED;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unseen_stream();
    test_directed_levels();
    test_random_traffic();
    test_ring_overflow();
    test_back_to_back();

    // drain, then give any late transaction time to show up
    item_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && status_expected.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (status_expected.size() != 0)
      report_mismatch($sformatf("%0d status transactions never arrived",
                                status_expected.size()));

    $display("sent %0d item transactions, checked %0d status transactions", items_sent,
             results_checked);
    $display("over %0d register settings incl. ring wrap and clock wrap; %0d mismatches",
             settings_applied, mismatch_count);
    if (mismatch_count == 0) begin
      $display("event_rate_staleness_monitor_unit regression: pass");
    end else begin
      $display("event_rate_staleness_monitor_unit regression: fail");
    end
    $finish;
  end

endmodule
